[rtl/pdp_pkg.sv]
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types, register indexes and saturating 48-bit arithmetic for the
// presum dot-product engine.
// ----------------------------------------------------------------------------
package pdp_pkg;

  localparam int AccW  = 48;
  localparam int ProdW = 33;

  localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

  // register indexes
  localparam logic [1:0] REG_INPUT_MODE  = 2'd0;
  localparam logic [1:0] REG_DEST1_FLAGS = 2'd1;
  localparam logic [1:0] REG_DEST2_FLAGS = 2'd2;

  // input_mode codes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_SUB    = 2'd2;

  // flag bit positions
  localparam int FLAG_NEG  = 0;
  localparam int FLAG_ACC  = 1;
  localparam int FLAG_BIAS = 2;
  localparam int FLAG_RELU = 3;
  localparam int FLAG_EN   = 4;

  typedef struct packed {
    logic [1:0] input_mode;
    logic [3:0] dest1_flags;
    logic [4:0] dest2_flags;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0]     a_value;
    logic signed [15:0]     b_value;
    logic signed [15:0]     weight;
    logic signed [AccW-1:0] prev_out1;
    logic signed [AccW-1:0] prev_out2;
    logic signed [31:0]     bias_one;
    logic signed [31:0]     bias_two;
    logic                   last;
  } in_word_t;

  typedef struct packed {
    logic signed [AccW-1:0] out1;
    logic signed [AccW-1:0] out2;
    logic                   out2_valid;
  } out_word_t;

  // product stage
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    logic signed [AccW-1:0]  prev1;
    logic signed [AccW-1:0]  prev2;
    logic signed [31:0]      bias1;
    logic signed [31:0]      bias2;
    logic                    last;
  } prod_word_t;

  // finished dot product plus epilogue operands
  typedef struct packed {
    logic signed [AccW-1:0] d1;
    logic signed [AccW-1:0] d2;
    logic signed [AccW-1:0] prev1;
    logic signed [AccW-1:0] prev2;
    logic signed [31:0]     bias1;
    logic signed [31:0]     bias2;
  } sum_word_t;

  function automatic logic signed [AccW-1:0] sat_add(
    input logic signed [AccW-1:0] x,
    input logic signed [AccW-1:0] y
  );
    logic signed [AccW:0] s;
    s = {x[AccW-1], x} + {y[AccW-1], y};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? ACC_MIN : ACC_MAX;
    end
    return s[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] sat_neg(input logic signed [AccW-1:0] x);
    if (x == ACC_MIN) begin
      return ACC_MAX;
    end
    return -x;
  endfunction

  function automatic logic signed [AccW-1:0] sext_prod(input logic signed [ProdW-1:0] p);
    return {{(AccW-ProdW){p[ProdW-1]}}, p};
  endfunction

  function automatic logic signed [AccW-1:0] sext_bias(input logic signed [31:0] b);
    return {{(AccW-32){b[31]}}, b};
  endfunction

endpackage

[rtl/pdp_in_if.sv]
// ----------------------------------------------------------------------------
// pdp_in_if
// Input channel: valid/ready handshake carrying one operand word.
// ----------------------------------------------------------------------------
interface pdp_in_if;
  import pdp_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/pdp_out_if.sv]
// ----------------------------------------------------------------------------
// pdp_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface pdp_out_if;
  import pdp_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/pdp_mac.sv]
// ----------------------------------------------------------------------------
// pdp_mac
// Input register, presum and multiply stage, saturating accumulator. Passes
// the finished sum on the word marked last.
// ----------------------------------------------------------------------------
module pdp_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  pdp_pkg::cfg_t         cfg,
  pdp_in_if.sink                din,
  output logic                  sum_valid,
  output pdp_pkg::sum_word_t    sum_word,
  input  logic                  sum_ready
);
  import pdp_pkg::*;

  logic                   v0;
  in_word_t               r0;
  logic                   v1;
  prod_word_t             r1;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] acc_next;

  logic                   s0_ready;
  logic                   s1_ready;
  logic                   s1_adv;
  logic                   s2_ready;
  logic signed [16:0]     presum;
  logic signed [ProdW-1:0] prod;

  assign s2_ready = !sum_valid || sum_ready;
  assign s1_adv   = v1 && (!r1.last || s2_ready);
  assign s1_ready = !v1 || s1_adv;
  assign s0_ready = !v0 || s1_ready;
  assign din.ready = s0_ready;

  always_comb begin
    case (cfg.input_mode)
      MODE_ADD: presum = 17'(r0.a_value) + 17'(r0.b_value);
      MODE_SUB: presum = 17'(r0.a_value) - 17'(r0.b_value);
      default:  presum = 17'(r0.a_value);
    endcase
    prod = presum * r0.weight;
  end

  assign acc_next = sat_add(acc, sext_prod(r1.prod));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (din.valid && s0_ready) begin
      v0 <= 1'b1;
    end else if (s1_ready) begin
      v0 <= 1'b0;
    end
    if (din.valid && s0_ready) begin
      r0 <= din.data;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_ready) begin
      v1 <= v0;
    end
    if (s1_ready && v0) begin
      r1.prod  <= prod;
      r1.prev1 <= r0.prev_out1;
      r1.prev2 <= r0.prev_out2;
      r1.bias1 <= r0.bias_one;
      r1.bias2 <= r0.bias_two;
      r1.last  <= r0.last;
    end
  end

  // accumulator and sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        acc <= r1.last ? '0 : acc_next;
      end
      if (s1_adv && r1.last) begin
        sum_valid <= 1'b1;
      end else if (sum_ready) begin
        sum_valid <= 1'b0;
      end
    end
    if (s1_adv && r1.last) begin
      sum_word.d1    <= acc_next;
      sum_word.d2    <= acc_next;
      sum_word.prev1 <= r1.prev1;
      sum_word.prev2 <= r1.prev2;
      sum_word.bias1 <= r1.bias1;
      sum_word.bias2 <= r1.bias2;
    end
  end

endmodule

[rtl/pdp_epi.sv]
// ----------------------------------------------------------------------------
// pdp_epi
// Dual-destination epilogue: negate, add previous value, add bias and ReLU,
// one saturating step per stage, ending in the output register.
// ----------------------------------------------------------------------------
module pdp_epi (
  input  logic                  clk,
  input  logic                  rst,
  input  pdp_pkg::cfg_t         cfg,
  input  logic                  sum_valid,
  input  pdp_pkg::sum_word_t    sum_word,
  output logic                  sum_ready,
  pdp_out_if.source             dout
);
  import pdp_pkg::*;

  logic      v3;
  sum_word_t r3;
  logic      v4;
  sum_word_t r4;

  logic      s3_ready;
  logic      s4_ready;
  logic      s5_ready;

  logic signed [AccW-1:0] neg1, neg2;
  logic signed [AccW-1:0] pv1, pv2;
  logic signed [AccW-1:0] bs1, bs2;
  logic                   en2;

  assign en2       = cfg.dest2_flags[FLAG_EN];
  assign s5_ready  = !dout.valid || dout.ready;
  assign s4_ready  = !v4 || s5_ready;
  assign s3_ready  = !v3 || s4_ready;
  assign sum_ready = s3_ready;

  always_comb begin
    neg1 = cfg.dest1_flags[FLAG_NEG] ? sat_neg(sum_word.d1) : sum_word.d1;
    neg2 = cfg.dest2_flags[FLAG_NEG] ? sat_neg(sum_word.d2) : sum_word.d2;
    pv1  = cfg.dest1_flags[FLAG_ACC] ? sat_add(r3.d1, r3.prev1) : r3.d1;
    pv2  = cfg.dest2_flags[FLAG_ACC] ? sat_add(r3.d2, r3.prev2) : r3.d2;
    bs1  = cfg.dest1_flags[FLAG_BIAS] ? sat_add(r4.d1, sext_bias(r4.bias1)) : r4.d1;
    bs2  = cfg.dest2_flags[FLAG_BIAS] ? sat_add(r4.d2, sext_bias(r4.bias2)) : r4.d2;
    if (cfg.dest1_flags[FLAG_RELU] && bs1[AccW-1]) begin
      bs1 = '0;
    end
    if (cfg.dest2_flags[FLAG_RELU] && bs2[AccW-1]) begin
      bs2 = '0;
    end
  end

  // negate
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (s3_ready) begin
      v3 <= sum_valid;
    end
    if (s3_ready && sum_valid) begin
      r3.d1    <= neg1;
      r3.d2    <= neg2;
      r3.prev1 <= sum_word.prev1;
      r3.prev2 <= sum_word.prev2;
      r3.bias1 <= sum_word.bias1;
      r3.bias2 <= sum_word.bias2;
    end
  end

  // add previous value
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (s4_ready) begin
      v4 <= v3;
    end
    if (s4_ready && v3) begin
      r4.d1    <= pv1;
      r4.d2    <= pv2;
      r4.prev1 <= r3.prev1;
      r4.prev2 <= r3.prev2;
      r4.bias1 <= r3.bias1;
      r4.bias2 <= r3.bias2;
    end
  end

  // bias, relu, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (s5_ready) begin
      dout.valid <= v4;
    end
    if (s5_ready && v4) begin
      dout.data.out1       <= bs1;
      dout.data.out2       <= en2 ? bs2 : '0;
      dout.data.out2_valid <= en2;
    end
  end

endmodule

[rtl/presum_dot_product_dual_epilogue.sv]
// ----------------------------------------------------------------------------
// presum_dot_product_dual_epilogue
// Streamed pointwise-convolution dot product with presum and dual epilogue.
// ----------------------------------------------------------------------------
// Takes one operand word per clock unless the epilogue stalls a finished sum.
// The presum multiply and the 48-bit saturating accumulator each sit between
// their own registers; the accumulate loop closes through one register. The
// sum register feeds three epilogue stages (negate, add previous, add bias
// with ReLU), the last being the output register. Configuration must be
// written only while no dot product is in flight; the block does not enforce it.
module presum_dot_product_dual_epilogue (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  pdp_in_if.sink     din,
  pdp_out_if.source  dout
);
  import pdp_pkg::*;

  cfg_t      cfg;
  logic      sum_valid;
  logic      sum_ready;
  sum_word_t sum_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_MODE:  cfg.input_mode  <= cfg_data[1:0];
        REG_DEST1_FLAGS: cfg.dest1_flags <= cfg_data[3:0];
        REG_DEST2_FLAGS: cfg.dest2_flags <= cfg_data;
        default: ;
      endcase
    end
  end

  pdp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .din       (din),
    .sum_valid (sum_valid),
    .sum_word  (sum_word),
    .sum_ready (sum_ready)
  );

  pdp_epi u_epi (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_word  (sum_word),
    .sum_ready (sum_ready),
    .dout      (dout)
  );

endmodule

[test/pdp_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_result_checker
// Watches the configuration port and both channels of the presum dot-product
// engine. Keeps its own copy of the registers and the running sum, predicts
// the epilogue outputs of every finished dot product, and compares each
// result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pdp_result_checker
  import pdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  pdp_in_if          in_ch,
  pdp_out_if         out_ch,
  output int         fail_count,
  output int         outstanding
);

  localparam longint SUM_MAX = (longint'(1) <<< (AccW - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int PRINT_LIMIT = 50;

  logic [1:0] input_mode;
  logic [3:0] dest1_flags;
  logic [4:0] dest2_flags;
  longint     running_sum;
  out_word_t  pending_results[$];

  function automatic longint clamp48(input longint v);
    if (v > SUM_MAX) begin
      return SUM_MAX;
    end
    if (v < SUM_MIN) begin
      return SUM_MIN;
    end
    return v;
  endfunction

  function automatic longint apply_epilogue(input longint sum, input logic [4:0] flags,
                                            input longint prev, input longint bias);
    longint v;
    v = sum;
    if (flags[FLAG_NEG]) begin
      v = clamp48(-v);
    end
    if (flags[FLAG_ACC]) begin
      v = clamp48(v + prev);
    end
    if (flags[FLAG_BIAS]) begin
      v = clamp48(v + bias);
    end
    if (flags[FLAG_RELU] && v < 0) begin
      v = 0;
    end
    return v;
  endfunction

  task automatic report(input string msg);
    if (fail_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    longint    a;
    longint    b;
    longint    w;
    longint    presum;
    if (rst) begin
      input_mode  = MODE_SINGLE;
      dest1_flags = '0;
      dest2_flags = '0;
      running_sum = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INPUT_MODE:  input_mode  = cfg_data[1:0];
          REG_DEST1_FLAGS: dest1_flags = cfg_data[3:0];
          REG_DEST2_FLAGS: dest2_flags = cfg_data;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          report($sformatf("result word with nothing expected: out1 %0d out2 %0d valid2 %0b",
                           $signed(got.out1), $signed(got.out2), got.out2_valid));
        end else begin
          want = pending_results.pop_front();
          if (got.out1 !== want.out1) begin
            report($sformatf("out1 got %0d expected %0d", $signed(got.out1),
                             $signed(want.out1)));
          end
          if (got.out2 !== want.out2) begin
            report($sformatf("out2 got %0d expected %0d", $signed(got.out2),
                             $signed(want.out2)));
          end
          if (got.out2_valid !== want.out2_valid) begin
            report($sformatf("out2_valid got %0b expected %0b", got.out2_valid,
                             want.out2_valid));
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        a = longint'($signed(in_ch.data.a_value));
        b = longint'($signed(in_ch.data.b_value));
        w = longint'($signed(in_ch.data.weight));
        case (input_mode)
          MODE_ADD: presum = a + b;
          MODE_SUB: presum = a - b;
          default:  presum = a;
        endcase
        running_sum = clamp48(running_sum + presum * w);
        if (in_ch.data.last) begin
          want.out1 = AccW'(apply_epilogue(running_sum, {1'b0, dest1_flags},
                                           longint'($signed(in_ch.data.prev_out1)),
                                           longint'($signed(in_ch.data.bias_one))));
          want.out2_valid = dest2_flags[FLAG_EN];
          want.out2 = '0;
          if (dest2_flags[FLAG_EN]) begin
            want.out2 = AccW'(apply_epilogue(running_sum, dest2_flags,
                                             longint'($signed(in_ch.data.prev_out2)),
                                             longint'($signed(in_ch.data.bias_two))));
          end
          pending_results.push_back(want);
          running_sum = 0;
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

[test/presum_dot_product_dual_epilogue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presum_dot_product_dual_epilogue_tb
// Drives the presum dot-product engine: directed dot products at the field
// extremes for every input mode and epilogue flag, two runs of full-scale
// products of either sign, then random dot products under fixed and random
// register settings, mostly with random gaps on both channels.
// ----------------------------------------------------------------------------
module presum_dot_product_dual_epilogue_tb;
  import pdp_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [4:0] F_NEG  = 5'(1 << FLAG_NEG);
  localparam logic [4:0] F_ACC  = 5'(1 << FLAG_ACC);
  localparam logic [4:0] F_BIAS = 5'(1 << FLAG_BIAS);
  localparam logic [4:0] F_RELU = 5'(1 << FLAG_RELU);
  localparam logic [4:0] F_EN   = 5'(1 << FLAG_EN);
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int SAT_RUN      = 24;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_WORDS  = 120;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;
  logic       quiet;
  int         fail_count;
  int         outstanding;
  int         stall_cycles;

  pdp_in_if  in_ch ();
  pdp_out_if out_ch ();

  presum_dot_product_dual_epilogue DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (in_ch),
    .dout      (out_ch)
  );

  pdp_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && (quiet || $urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return ACC_MAX;
      1: return ACC_MIN;
      2, 3: return {{12{r[35]}}, r[35:0]};
      default: return r[47:0];
    endcase
  endfunction

  function automatic in_word_t make_word(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] w, input logic [47:0] p1,
                                         input logic [47:0] p2, input logic [31:0] b1,
                                         input logic [31:0] b2, input logic last);
    in_word_t word;
    word.a_value   = a;
    word.b_value   = b;
    word.weight    = w;
    word.prev_out1 = p1;
    word.prev_out2 = p2;
    word.bias_one  = b1;
    word.bias_two  = b2;
    word.last      = last;
    return word;
  endfunction

  function automatic in_word_t random_word(input logic last);
    return make_word(pick16(), pick16(), pick16(), pick48(), pick48(), pick32(), pick32(),
                     last);
  endfunction

  task automatic send_word(input in_word_t word);
    while (!quiet && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= word;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // hold off the sender until every result is out and the pipe is empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [4:0] mode, input logic [4:0] f1,
                            input logic [4:0] f2);
    write_reg(REG_INPUT_MODE, mode);
    write_reg(REG_DEST1_FLAGS, f1);
    write_reg(REG_DEST2_FLAGS, f2);
    cfg_we <= 1'b0;
  endtask

  task automatic saturate_run(input logic [15:0] w, input logic end_random);
    repeat (SAT_RUN) send_word(make_word(16'h8000, 16'h7fff, w, '0, '0, '0, '0, 1'b0));
    if (end_random) begin
      send_word(make_word(16'h8000, 16'h7fff, 16'h7fff, '0, '0, '0, '0, 1'b0));
      send_word(random_word(1'b0));
    end
    send_word(make_word(16'h8000, 16'h7fff, w, pick48(), pick48(), pick32(), pick32(), 1'b1));
  endtask

  initial begin
    int sent;
    int len;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_INPUT_MODE;
    cfg_data     = '0;
    quiet        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single input, destination two off
    set_config({3'b0, MODE_SINGLE}, 5'd0, 5'd0);
    send_word(make_word(16'h7fff, 16'h1234, 16'h7fff, ACC_MAX, ACC_MIN, '1, '1, 1'b1));
    send_word(make_word(16'h8000, 16'h7fff, 16'h8000, '0, '0, '0, '0, 1'b0));
    send_word(make_word(16'h8000, 16'h7fff, 16'h7fff, '0, '0, '0, '0, 1'b1));
    send_word(make_word('0, '0, '0, '0, '0, '0, '0, 1'b1));
    drain();

    // add mode, epilogue adds saturating both ways
    set_config({3'b0, MODE_ADD}, F_NEG | F_ACC | F_BIAS, F_EN | F_NEG | F_ACC | F_BIAS | F_RELU);
    send_word(make_word(16'h8000, 16'h8000, 16'h8000, '0, '0, '0, '0, 1'b0));
    send_word(make_word(16'h7fff, 16'h7fff, 16'h7fff, ACC_MAX, ACC_MIN, 32'h7fff_ffff,
                        32'h8000_0000, 1'b1));
    send_word(make_word(16'h0001, 16'h0002, 16'hffff, ACC_MIN, ACC_MAX, 32'h8000_0000,
                        32'h7fff_ffff, 1'b1));
    send_word(make_word(16'h0100, 16'hff00, 16'h0100, 48'h0000_0001_0000, '1, 32'h0001_0000,
                        '1, 1'b1));
    drain();

    // subtract mode, all destination one flags, relu on two
    set_config({3'b0, MODE_SUB}, F_NEG | F_ACC | F_BIAS | F_RELU, F_EN | F_RELU | F_BIAS);
    send_word(make_word(16'h8000, 16'h7fff, 16'h7fff, 48'h0000_0010_0000, '0, 32'hffff_0000,
                        32'h0000_ffff, 1'b1));
    send_word(make_word(16'h7fff, 16'h8000, 16'h8000, 48'hffff_ffff_0000, '0, 32'h0001_0000,
                        32'h8000_0000, 1'b1));
    send_word(make_word(16'h0003, 16'h0005, 16'h0002, '0, '0, '0, 32'h7fff_ffff, 1'b1));
    drain();

    // mode three acts as single input; upper data bits masked; unused index
    set_config({3'b111, MODE_UNUSED}, 5'b11000, F_EN | F_ACC);
    write_reg(REG_UNUSED, 5'b11111);
    cfg_we <= 1'b0;
    send_word(make_word(16'h0064, 16'h7fff, 16'hfffd, '0, 48'h7fff_0000_0000, '0, '0, 1'b0));
    send_word(make_word(16'h8000, 16'h8000, 16'h0001, '0, ACC_MAX, '0, '0, 1'b1));
    send_word(make_word(16'h0001, 16'h7fff, 16'h0001, '0, ACC_MIN, '0, '0, 1'b1));
    drain();

    // full-scale positive products, then pulled down by a negative one and a random word
    quiet = 1'b1;
    set_config({3'b0, MODE_SUB}, 5'd0, F_EN | F_NEG);
    saturate_run(16'h8000, 1'b1);
    drain();

    // full-scale negative products
    set_config({3'b0, MODE_SUB}, F_NEG, F_EN | F_RELU);
    saturate_run(16'h7fff, 1'b0);
    drain();
    quiet = 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        set_config(5'd0, 5'd0, 5'd0);
      end else if (ph == 1) begin
        set_config(5'h1f, 5'h1f, 5'h1f);
      end else begin
        if ($urandom_range(3) == 0) begin
          write_reg(REG_UNUSED, 5'($urandom));
        end
        set_config(5'($urandom), 5'($urandom), 5'($urandom));
      end
      quiet = (ph == 5 || ph == 6);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          send_word(random_word(i == len - 1));
        end
        sent += len;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
